// ===== hw/rtl/tlb_pkg.sv =====
package tlb_pkg;

    localparam int OP_W    = 2;
    localparam int PROC_W  = 16;
    localparam int PAGE_W  = 20;
    localparam int FRAME_W = 20;
    localparam int CFG_W   = 5;
    localparam int TDATA_W = 64;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH  = 2'd2;

    localparam logic REG_TLB_ENTRIES = 1'b0;
    localparam logic REG_LRU_MODE    = 1'b1;

    typedef struct packed {
        logic [PROC_W-1:0]  proc_id;
        logic [PAGE_W-1:0]  page_num;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef enum logic [2:0] {
        CO_HOLD,
        CO_LRU,
        CO_ADD_EVICT,
        CO_ADD,
        CO_FLUSH,
        CO_CLEAR
    } t_cell_op;

    // Broadcast to every cell of the row in each cycle.
    typedef struct packed {
        t_cell_op          op;
        t_entry            ld;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ===== hw/rtl/tlb_cell.sv =====
module tlb_cell #(
    parameter int IDX    = 0,
    parameter int FILL_W = 5
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tlb_pkg::t_cell_ctl          i_ctl,
    input  logic [tlb_pkg::PROC_W-1:0]  i_key_proc,
    input  logic [tlb_pkg::PAGE_W-1:0]  i_key_page,
    input  logic [FILL_W-1:0]           i_fill,
    input  logic                        i_found,
    input  tlb_pkg::t_entry             i_right,
    input  logic                        i_right_valid,
    output logic                        o_found,
    output tlb_pkg::t_entry             o_entry,
    output logic                        o_valid,
    output tlb_pkg::t_entry             o_sel
);

    tlb_pkg::t_entry r_entry;
    tlb_pkg::t_entry n_entry;
    logic            r_valid;
    logic            n_valid;
    logic            in_use;
    logic            is_last;
    logic            is_next;
    logic            match;

    assign in_use  = FILL_W'(IDX) < i_fill;
    assign is_last = i_fill == FILL_W'(IDX + 1);
    assign is_next = i_fill == FILL_W'(IDX);
    assign match   = r_valid && in_use && (r_entry.proc_id == i_key_proc)
                     && (r_entry.page_num == i_key_page);

    // The oldest matching entry wins, so the found flag ripples from old to new.
    assign o_found = i_found | match;
    assign o_sel   = (match && !i_found) ? r_entry : '0;
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        case (i_ctl.op)
            tlb_pkg::CO_LRU: begin
                // Entries younger than the hit move one place toward the old end.
                if (o_found && is_last) begin
                    n_entry = i_ctl.ld;
                    n_valid = 1'b1;
                end else if (o_found && in_use) begin
                    n_entry = i_right;
                    n_valid = i_right_valid;
                end
            end
            tlb_pkg::CO_ADD_EVICT: begin
                if (is_last) begin
                    n_entry = i_ctl.ld;
                    n_valid = 1'b1;
                end else if (in_use) begin
                    n_entry = i_right;
                    n_valid = i_right_valid;
                end
            end
            tlb_pkg::CO_ADD: begin
                if (is_next) begin
                    n_entry = i_ctl.ld;
                    n_valid = 1'b1;
                end
            end
            tlb_pkg::CO_FLUSH, tlb_pkg::CO_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ===== hw/rtl/tlb_fifo_lru_translation_core.sv =====
// Fully associative TLB built as a row of entry cells kept in age order, the
// oldest at the left. Each item is captured in S_IDLE; then, in S_EXEC, every
// cell compares the key at once and the row shifts to drop, append or move
// an entry to the newest end. The next item is taken once S_EXEC is done,
// while the result may still wait in the output register; no new item is
// taken while one is in S_EXEC. If the previous result is still unread when
// an item reaches S_EXEC, S_EXEC holds until the output register frees up.
// A write to either register empties the store in the cycle of the write;
// no clearing pass follows reset.
module tlb_fifo_lru_translation_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // op[1:0], proc_id[17:2], page_num[37:18], frame_in[57:38], zeros above
    input  logic [tlb_pkg::TDATA_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // hit[0], frame_out[20:1], evicted[21], evicted_proc[37:22],
    // evicted_page[57:38], zeros above
    output logic [tlb_pkg::TDATA_W-1:0]   m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlb_pkg::PADDR_W-1:0]   paddr,
    input  logic [tlb_pkg::APB_W-1:0]     pwdata,
    output logic [tlb_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    localparam int FILL_W = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W  = (FILL_W > tlb_pkg::CFG_W) ? FILL_W : tlb_pkg::CFG_W;
    localparam int PAD_W  = tlb_pkg::TDATA_W - 1 - tlb_pkg::FRAME_W - 1
                            - tlb_pkg::PROC_W - tlb_pkg::PAGE_W;

    tlb_pkg::t_state                r_state;
    tlb_pkg::t_state                n_state;
    logic [tlb_pkg::CFG_W-1:0]      r_tlb_entries;
    logic                           r_lru_mode;
    logic [FILL_W-1:0]              r_fill;
    logic [FILL_W-1:0]              n_fill;
    logic [tlb_pkg::OP_W-1:0]       r_op;
    tlb_pkg::t_entry                r_key;
    logic                           r_out_valid;
    logic                           r_hit;
    logic [tlb_pkg::FRAME_W-1:0]    r_frame_out;
    logic                           r_evicted;
    logic [tlb_pkg::PROC_W-1:0]     r_ev_proc;
    logic [tlb_pkg::PAGE_W-1:0]     r_ev_page;

    logic                           cfg_wr;
    logic                           in_acc;
    logic                           do_exec;
    logic [CNT_W-1:0]               eff_cnt;
    logic                           enabled;
    logic                           evict;
    logic                           hit;
    tlb_pkg::t_cell_ctl             ctl;
    tlb_pkg::t_entry                sel_or;

    logic                           found [MAX_ENTRIES+1];
    tlb_pkg::t_entry                ent   [MAX_ENTRIES];
    logic                           vld   [MAX_ENTRIES];
    tlb_pkg::t_entry                sel   [MAX_ENTRIES];

    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign s_axis_tready = (r_state == tlb_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign do_exec       = (r_state == tlb_pkg::S_EXEC) && (!r_out_valid || m_axis_tready);

    assign eff_cnt = (CNT_W'(r_tlb_entries) > CNT_W'(MAX_ENTRIES)) ?
                     CNT_W'(MAX_ENTRIES) : CNT_W'(r_tlb_entries);
    assign enabled = eff_cnt != '0;
    assign evict   = (CNT_W'(r_fill) >= eff_cnt) && (r_fill != '0);
    assign hit     = (r_op == tlb_pkg::OP_LOOKUP) && enabled && found[MAX_ENTRIES];

    always_comb begin
        prdata = '0;
        case (paddr[2])
            tlb_pkg::REG_TLB_ENTRIES: prdata = tlb_pkg::APB_W'(r_tlb_entries);
            tlb_pkg::REG_LRU_MODE:    prdata = tlb_pkg::APB_W'(r_lru_mode);
            default:                  prdata = '0;
        endcase
    end

    always_comb begin
        sel_or = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            sel_or = sel_or | sel[i];
        end
    end

    always_comb begin
        ctl.ld = r_key;
        ctl.op = tlb_pkg::CO_HOLD;
        if (cfg_wr) begin
            ctl.op = tlb_pkg::CO_CLEAR;
        end else if (do_exec) begin
            case (r_op)
                tlb_pkg::OP_LOOKUP: begin
                    if (hit && r_lru_mode) begin
                        ctl.op = tlb_pkg::CO_LRU;
                        ctl.ld = sel_or;
                    end
                end
                tlb_pkg::OP_ADD: begin
                    if (enabled) begin
                        ctl.op = evict ? tlb_pkg::CO_ADD_EVICT : tlb_pkg::CO_ADD;
                    end
                end
                tlb_pkg::OP_FLUSH: ctl.op = tlb_pkg::CO_FLUSH;
                default:           ctl.op = tlb_pkg::CO_HOLD;
            endcase
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (ctl.op == tlb_pkg::CO_CLEAR) begin
            n_fill = '0;
        end else if (ctl.op == tlb_pkg::CO_ADD) begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlb_pkg::S_IDLE: if (in_acc) n_state = tlb_pkg::S_EXEC;
            tlb_pkg::S_EXEC: if (do_exec) n_state = tlb_pkg::S_IDLE;
            default:         n_state = tlb_pkg::S_IDLE;
        endcase
    end

    assign found[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        tlb_pkg::t_entry right;
        logic            right_valid;
        if (g == MAX_ENTRIES - 1) begin : g_end
            assign right       = '0;
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right       = ent[g+1];
            assign right_valid = vld[g+1];
        end
        tlb_cell #(
            .IDX    (g),
            .FILL_W (FILL_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_key_proc    (r_key.proc_id),
            .i_key_page    (r_key.page_num),
            .i_fill        (r_fill),
            .i_found       (found[g]),
            .i_right       (right),
            .i_right_valid (right_valid),
            .o_found       (found[g+1]),
            .o_entry       (ent[g]),
            .o_valid       (vld[g]),
            .o_sel         (sel[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op           <= s_axis_tdata[1:0];
            r_key.proc_id  <= s_axis_tdata[17:2];
            r_key.page_num <= s_axis_tdata[37:18];
            r_key.frame    <= s_axis_tdata[57:38];
        end
        if (do_exec) begin
            r_hit       <= hit;
            r_frame_out <= hit ? sel_or.frame : '0;
            r_evicted   <= (ctl.op == tlb_pkg::CO_ADD_EVICT);
            r_ev_proc   <= (ctl.op == tlb_pkg::CO_ADD_EVICT) ? ent[0].proc_id : '0;
            r_ev_page   <= (ctl.op == tlb_pkg::CO_ADD_EVICT) ? ent[0].page_num : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tlb_pkg::S_IDLE;
            r_tlb_entries <= tlb_pkg::CFG_W'(4);
            r_lru_mode    <= 1'b0;
            r_fill        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (cfg_wr) begin
                case (paddr[2])
                    tlb_pkg::REG_TLB_ENTRIES: r_tlb_entries <= pwdata[tlb_pkg::CFG_W-1:0];
                    tlb_pkg::REG_LRU_MODE:    r_lru_mode    <= pwdata[0];
                    default: begin
                    end
                endcase
            end
            if (do_exec) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_ev_page, r_ev_proc, r_evicted, r_frame_out, r_hit};

    // The list never grows beyond the row of cells.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(MAX_ENTRIES))
        else $error("fill count beyond the number of cells");

    // A register write leaves the store empty.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_fill == '0))
        else $error("store not emptied by a register write");

    // A result reports either a hit or an eviction, never both.
    a_hit_xor_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_hit && r_evicted))
        else $error("hit and eviction in one result");

    // An item waiting for a blocked output stays in the execute state.
    a_exec_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tlb_pkg::S_EXEC) && r_out_valid && !m_axis_tready
        |=> (r_state == tlb_pkg::S_EXEC))
        else $error("item left execute while the output was blocked");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    localparam int SLOTS       = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 135;
    localparam logic [tlb_pkg::OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [tlb_pkg::FRAME_W-1:0] frame_in;
        logic [tlb_pkg::PAGE_W-1:0]  page_num;
        logic [tlb_pkg::PROC_W-1:0]  proc_id;
        logic [tlb_pkg::OP_W-1:0]    op;
    } t_req;

    typedef struct packed {
        logic [tlb_pkg::PAGE_W-1:0]  evicted_page;
        logic [tlb_pkg::PROC_W-1:0]  evicted_proc;
        logic                        evicted;
        logic [tlb_pkg::FRAME_W-1:0] frame_out;
        logic                        hit;
    } t_reply;

    localparam int REPLY_W = $bits(t_reply);

    // Mirror of the translation store plus the queue of replies still owed.
    class t_shadow;
        logic [tlb_pkg::PROC_W-1:0]  key_proc [SLOTS];
        logic [tlb_pkg::PAGE_W-1:0]  key_page [SLOTS];
        logic [tlb_pkg::FRAME_W-1:0] frame_of [SLOTS];
        bit                          live     [SLOTS];
        int                          filled;
        int                          entries;
        bit                          lru;
        t_reply                      pending [$];
        int                          mismatch_count;
        int                          replies_seen;

        function new();
            entries        = 4;
            lru            = 1'b0;
            filled         = 0;
            mismatch_count = 0;
            replies_seen   = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        function void set_register(logic idx, logic [tlb_pkg::APB_W-1:0] value);
            if (idx == tlb_pkg::REG_TLB_ENTRIES) begin
                entries = (int'(value[tlb_pkg::CFG_W-1:0]) > SLOTS) ? SLOTS
                          : int'(value[tlb_pkg::CFG_W-1:0]);
            end else begin
                lru = value[0];
            end
            filled = 0;
            foreach (live[i]) live[i] = 1'b0;
        endfunction

        // Moves one entry to the newest end; every younger entry slides down.
        function void rotate_to_newest(int idx);
            logic [tlb_pkg::PROC_W-1:0]  p;
            logic [tlb_pkg::PAGE_W-1:0]  g;
            logic [tlb_pkg::FRAME_W-1:0] f;
            bit                          v;
            p = key_proc[idx];
            g = key_page[idx];
            f = frame_of[idx];
            v = live[idx];
            for (int i = idx; i + 1 < filled; i++) begin
                key_proc[i] = key_proc[i + 1];
                key_page[i] = key_page[i + 1];
                frame_of[i] = frame_of[i + 1];
                live[i]     = live[i + 1];
            end
            key_proc[filled - 1] = p;
            key_page[filled - 1] = g;
            frame_of[filled - 1] = f;
            live[filled - 1]     = v;
        endfunction

        function void note_request(t_req req);
            t_reply r;
            int     found;
            r     = '0;
            found = -1;
            case (req.op)
                tlb_pkg::OP_LOOKUP: if (entries > 0) begin
                    for (int i = 0; i < filled && found < 0; i++) begin
                        if (live[i] && key_proc[i] == req.proc_id && key_page[i] == req.page_num)
                            found = i;
                    end
                    if (found >= 0) begin
                        r.hit       = 1'b1;
                        r.frame_out = frame_of[found];
                        if (lru) rotate_to_newest(found);
                    end
                end
                tlb_pkg::OP_ADD: if (entries > 0) begin
                    if (filled >= entries) begin
                        r.evicted      = 1'b1;
                        r.evicted_proc = key_proc[0];
                        r.evicted_page = key_page[0];
                        // The oldest entry goes whether it is valid or not.
                        rotate_to_newest(0);
                        filled--;
                    end
                    key_proc[filled] = req.proc_id;
                    key_page[filled] = req.page_num;
                    frame_of[filled] = req.frame_in;
                    live[filled]     = 1'b1;
                    filled++;
                end
                tlb_pkg::OP_FLUSH: begin
                    foreach (live[i]) live[i] = 1'b0;
                end
                default: begin
                end
            endcase
            pending.push_back(r);
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            mismatch_count++;
            if (mismatch_count <= 50)
                $display("reply %0d: %s is %0h, expected %0h", replies_seen, field, got, want);
        endtask

        task check_reply(logic [tlb_pkg::TDATA_W-1:0] data);
            t_reply got;
            t_reply want;
            got = data[REPLY_W-1:0];
            replies_seen++;
            if (pending.size() == 0) begin
                report_mismatch("reply with nothing outstanding", 64'(data), 64'(0));
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit)
                report_mismatch("hit", 64'(got.hit), 64'(want.hit));
            if (got.frame_out !== want.frame_out)
                report_mismatch("frame_out", 64'(got.frame_out), 64'(want.frame_out));
            if (got.evicted !== want.evicted)
                report_mismatch("evicted", 64'(got.evicted), 64'(want.evicted));
            if (got.evicted_proc !== want.evicted_proc)
                report_mismatch("evicted_proc", 64'(got.evicted_proc), 64'(want.evicted_proc));
            if (got.evicted_page !== want.evicted_page)
                report_mismatch("evicted_page", 64'(got.evicted_page), 64'(want.evicted_page));
            if (data[tlb_pkg::TDATA_W-1:REPLY_W] !== '0)
                report_mismatch("upper tdata bits", 64'(data[tlb_pkg::TDATA_W-1:REPLY_W]),
                                64'(0));
        endtask
    endclass

    logic                         i_clk         = 1'b0;
    logic                         i_rst_n       = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    // op[1:0], proc_id[17:2], page_num[37:18], frame_in[57:38], zeros above
    logic [tlb_pkg::TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    // hit[0], frame_out[20:1], evicted[21], evicted_proc[37:22],
    // evicted_page[57:38], zeros above
    logic [tlb_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [tlb_pkg::PADDR_W-1:0]  paddr         = '0;
    logic [tlb_pkg::APB_W-1:0]    pwdata        = '0;
    logic [tlb_pkg::APB_W-1:0]    prdata;
    logic                         pready;

    t_shadow                      shadow;
    int                           cycle_count = 0;
    int                           stall_left  = 0;
    bit                           calm        = 1'b0;
    logic [tlb_pkg::PROC_W-1:0]   pool_proc [24];
    logic [tlb_pkg::PAGE_W-1:0]   pool_page [24];
    int                           pool_size   = 2;
    int                           phase_entries [10] = '{0, 1, 1, 16, 16, 31, 17, 2, 4, 8};
    bit                           phase_lru     [10] = '{0, 0, 1, 1, 0, 1, 0, 1, 0, 1};

    tlb_fifo_lru_translation_core #(.MAX_ENTRIES(SLOTS)) DUT (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tlb_fifo_lru_translation_core regression: fail");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) return 0;
        if (roll < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (calm || $urandom_range(0, 9) < 7) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            shadow.check_reply(m_axis_tdata);
    end

    function automatic t_req make_req(logic [tlb_pkg::OP_W-1:0] op,
                                      logic [tlb_pkg::PROC_W-1:0] proc_id,
                                      logic [tlb_pkg::PAGE_W-1:0] page_num,
                                      logic [tlb_pkg::FRAME_W-1:0] frame_in);
        t_req req;
        req.op       = op;
        req.proc_id  = proc_id;
        req.page_num = page_num;
        req.frame_in = frame_in;
        return req;
    endfunction

    function automatic t_req random_req();
        t_req req;
        int   roll;
        int   k;
        roll         = $urandom_range(0, 99);
        k            = $urandom_range(0, pool_size - 1);
        req.proc_id  = pool_proc[k];
        req.page_num = pool_page[k];
        req.frame_in = tlb_pkg::FRAME_W'($urandom);
        if (roll < 48) req.op = tlb_pkg::OP_LOOKUP;
        else if (roll < 92) req.op = tlb_pkg::OP_ADD;
        else if (roll < 97) req.op = tlb_pkg::OP_FLUSH;
        else req.op = OP_RESERVED;
        // A few keys are near misses or come from outside the pool.
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            req.page_num ^= tlb_pkg::PAGE_W'(1) << $urandom_range(0, tlb_pkg::PAGE_W - 1);
        end else if (roll == 1) begin
            req.proc_id ^= tlb_pkg::PROC_W'(1) << $urandom_range(0, tlb_pkg::PROC_W - 1);
        end else if (roll == 2) begin
            req.proc_id  = tlb_pkg::PROC_W'($urandom);
            req.page_num = tlb_pkg::PAGE_W'($urandom);
        end
        return req;
    endfunction

    task automatic send_item(input t_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= tlb_pkg::TDATA_W'(req);
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.note_request(req);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Setup and access cycles of one register write; psel stays high on return.
    task automatic apb_write(input logic idx, input logic [tlb_pkg::APB_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow.set_register(idx, value);
    endtask

    task automatic configure(input logic [tlb_pkg::APB_W-1:0] entry_count, input bit lru_on);
        apb_write(tlb_pkg::REG_TLB_ENTRIES, entry_count);
        apb_write(tlb_pkg::REG_LRU_MODE, tlb_pkg::APB_W'(lru_on));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [tlb_pkg::APB_W-1:0] entry_count, input bit lru_on);
        drain();
        configure(entry_count, lru_on);
        calm      = ($urandom_range(0, 3) == 0);
        pool_size = $urandom_range(2, 24);
        for (int k = 0; k < pool_size; k++) begin
            pool_proc[k] = tlb_pkg::PROC_W'($urandom);
            pool_page[k] = tlb_pkg::PAGE_W'($urandom);
            // Shared process ids and shared pages make partial matches common.
            if (k > 0 && $urandom_range(0, 2) == 0) pool_proc[k] = pool_proc[0];
            else if (k > 0 && $urandom_range(0, 3) == 0) pool_page[k] = pool_page[0];
        end
        repeat (PHASE_ITEMS) send_item(random_req());
    endtask

    initial begin
        shadow = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: four entries in FIFO order.
        send_item(make_req(tlb_pkg::OP_LOOKUP, '0, '0, '0));
        send_item(make_req(tlb_pkg::OP_ADD, '1, '1, '1));
        send_item(make_req(tlb_pkg::OP_ADD, '0, '0, '0));
        send_item(make_req(tlb_pkg::OP_LOOKUP, '1, '1, '0));
        send_item(make_req(tlb_pkg::OP_LOOKUP, '0, '0, '1));
        send_item(make_req(tlb_pkg::OP_ADD, 16'h1234, 20'h0abcd, 20'h55555));
        send_item(make_req(tlb_pkg::OP_ADD, 16'h1234, 20'h0abce, 20'haaaaa));
        // The store is full here, so the all-ones entry is dropped.
        send_item(make_req(tlb_pkg::OP_ADD, 16'h4321, 20'h0abcd, 20'h00f0f));
        send_item(make_req(OP_RESERVED, '1, '1, '1));
        send_item(make_req(tlb_pkg::OP_LOOKUP, '1, '1, '0));
        send_item(make_req(tlb_pkg::OP_FLUSH, '0, '0, '0));
        send_item(make_req(tlb_pkg::OP_LOOKUP, 16'h1234, 20'h0abcd, '0));
        // After the flush the oldest entry is invalid but is still evicted.
        send_item(make_req(tlb_pkg::OP_ADD, 16'h0001, 20'h00001, 20'h12345));

        drain();
        configure(3, 1'b1);
        send_item(make_req(tlb_pkg::OP_ADD, 16'haaaa, 20'h11111, 20'h00001));
        send_item(make_req(tlb_pkg::OP_ADD, 16'h5555, 20'h22222, 20'h00002));
        send_item(make_req(tlb_pkg::OP_ADD, 16'haaaa, 20'h33333, 20'h00003));
        send_item(make_req(tlb_pkg::OP_LOOKUP, 16'haaaa, 20'h11111, '0));
        // The hit above made the first entry newest, so the second one goes.
        send_item(make_req(tlb_pkg::OP_ADD, 16'h5555, 20'h44444, 20'h00004));
        send_item(make_req(tlb_pkg::OP_LOOKUP, 16'haaaa, 20'h11111, '0));

        drain();
        configure(0, 1'b0);
        send_item(make_req(tlb_pkg::OP_ADD, 16'h0f0f, 20'hf0f0f, 20'h0ffff));
        send_item(make_req(tlb_pkg::OP_LOOKUP, 16'h0f0f, 20'hf0f0f, '0));
        send_item(make_req(tlb_pkg::OP_FLUSH, '1, '1, '1));

        for (int p = 0; p < 12; p++) begin
            if (p < 10)
                run_phase(tlb_pkg::APB_W'(phase_entries[p]), phase_lru[p]);
            else
                run_phase(tlb_pkg::APB_W'($urandom_range(1, SLOTS)), 1'($urandom_range(0, 1)));
        end

        drain();
        if (shadow.mismatch_count == 0 && shadow.pending.size() == 0) begin
            $display("tlb_fifo_lru_translation_core regression: pass");
        end else begin
            $display("tlb_fifo_lru_translation_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/tlb_pkg.sv
hw/rtl/tlb_cell.sv
hw/rtl/tlb_fifo_lru_translation_core.sv
dv/tb_top.sv
